@@ design/hic_pkg.sv @@
// Shared types and constants for the homography inlier check.
// No dependencies.
`default_nettype none
package hic_pkg;
	localparam int unsigned COORD_W_DEF = 20;
	localparam int unsigned COEF_W_DEF = 32;
	localparam int unsigned THR_W = 10;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [31:0] H22_RESET = 32'd16777216;
	localparam logic [THR_W-1:0] THR_RESET = 10'd48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_H00_H01 = 3'd0,
		REG_H02_H10 = 3'd1,
		REG_H11_H12 = 3'd2,
		REG_H20_H21 = 3'd3,
		REG_H22     = 3'd4,
		REG_THR     = 3'd5
	} cfg_idx_t;

	// raw 32-bit coefficient words; users take the low COEF_WIDTH bits
	typedef struct packed {
		logic [31:0] h00;
		logic [31:0] h01;
		logic [31:0] h02;
		logic [31:0] h10;
		logic [31:0] h11;
		logic [31:0] h12;
		logic [31:0] h20;
		logic [31:0] h21;
		logic [31:0] h22;
		logic [THR_W-1:0] thr;
	} coef_t;
endpackage
`default_nettype wire

@@ design/hic_if.sv @@
// Channel interfaces: point pair input, result output, register write.
// Depends on hic_pkg.
`default_nettype none
interface hic_pair_if import hic_pkg::*; #(parameter int unsigned W = COORD_W_DEF) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] query_x;
	logic signed [W-1:0] query_y;
	logic signed [W-1:0] train_x;
	logic signed [W-1:0] train_y;
	modport source (output valid, query_x, query_y, train_x, train_y, input ready);
	modport sink (input valid, query_x, query_y, train_x, train_y, output ready);
endinterface

interface hic_result_if import hic_pkg::*; #(parameter int unsigned W = COORD_W_DEF) ();
	logic valid;
	logic ready;
	logic is_inlier;
	logic degenerate;
	logic signed [W-1:0] pair_query_x;
	logic signed [W-1:0] pair_query_y;
	logic signed [W-1:0] pair_train_x;
	logic signed [W-1:0] pair_train_y;
	modport source (output valid, is_inlier, degenerate, pair_query_x, pair_query_y,
		pair_train_x, pair_train_y, input ready);
	modport sink (input valid, is_inlier, degenerate, pair_query_x, pair_query_y,
		pair_train_x, pair_train_y, output ready);
endinterface

interface hic_cfg_if import hic_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/hic_cfg.sv @@
// Configuration register file: homography coefficients and threshold.
// Depends on hic_pkg and hic_cfg_if.
`default_nettype none
module hic_cfg import hic_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	hic_cfg_if.sink   cfg,
	output coef_t     coef
);
	logic [63:0] r0_q, r1_q, r2_q, r3_q;
	logic [31:0] h22_q;
	logic [THR_W-1:0] thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q  <= '0;
			r1_q  <= '0;
			r2_q  <= '0;
			r3_q  <= '0;
			h22_q <= H22_RESET;
			thr_q <= THR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_H00_H01: r0_q <= cfg.data;
				REG_H02_H10: r1_q <= cfg.data;
				REG_H11_H12: r2_q <= cfg.data;
				REG_H20_H21: r3_q <= cfg.data;
				REG_H22:     h22_q <= cfg.data[31:0];
				REG_THR:     thr_q <= cfg.data[THR_W-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	always_comb begin
		coef.h00 = r0_q[63:32];
		coef.h01 = r0_q[31:0];
		coef.h02 = r1_q[63:32];
		coef.h10 = r1_q[31:0];
		coef.h11 = r2_q[63:32];
		coef.h12 = r2_q[31:0];
		coef.h20 = r3_q[63:32];
		coef.h21 = r3_q[31:0];
		coef.h22 = h22_q;
		coef.thr = thr_q;
	end
endmodule
`default_nettype wire

@@ design/hic_proj.sv @@
// Projection front end, stages 1-4: products, xn/yn/w sums, split t*w,
// then error terms ex, ey and threshold term t*w. Depends on hic_pkg.
`default_nettype none
module hic_proj import hic_pkg::*; #(
	parameter int unsigned C = COORD_W_DEF,
	parameter int unsigned K = COEF_W_DEF,
	parameter int unsigned XW = K + C + 2,
	parameter int unsigned EW = C + XW + 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic signed [C-1:0] qx,
	input  wire logic signed [C-1:0] qy,
	input  wire logic signed [C-1:0] tx,
	input  wire logic signed [C-1:0] ty,
	input  coef_t coef,
	output logic v_out,
	output logic deg_out,
	output logic [4*C-1:0] echo_out,
	output logic signed [EW-1:0] ex_out,
	output logic signed [EW-1:0] ey_out,
	output logic signed [EW-1:0] tw_out
);
	localparam int unsigned PW = K + C;
	localparam int unsigned WL = XW / 2;
	localparam int unsigned WH = XW - WL;

	logic signed [K-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
	logic signed [THR_W:0] thr;
	logic signed [XW-1:0] t02, t12, t22;

	assign h00 = coef.h00[K-1:0];
	assign h01 = coef.h01[K-1:0];
	assign h02 = coef.h02[K-1:0];
	assign h10 = coef.h10[K-1:0];
	assign h11 = coef.h11[K-1:0];
	assign h12 = coef.h12[K-1:0];
	assign h20 = coef.h20[K-1:0];
	assign h21 = coef.h21[K-1:0];
	assign h22 = coef.h22[K-1:0];
	assign thr = $signed({1'b0, coef.thr});
	// translations to 28 fraction bits, h22 to 34
	assign t02 = XW'(h02) <<< 12;
	assign t12 = XW'(h12) <<< 12;
	assign t22 = XW'(h22) <<< 10;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PW-1:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	logic signed [C-1:0] tx_s1, ty_s1, tx_s2, ty_s2;
	logic [4*C-1:0] echo_s1, echo_s2, echo_s3, echo_s4;
	logic signed [XW-1:0] xn_s2, yn_s2, w_s2;
	logic deg_s3, deg_s4;
	logic signed [EW-1:0] xs_s3, ys_s3;
	logic signed [C+WL:0] txl_s3, tyl_s3;
	logic signed [C+WH-1:0] txh_s3, tyh_s3;
	logic signed [XW+THR_W:0] tw_s3;
	logic signed [EW-1:0] ex_s4, ey_s4, tw_s4;
	logic signed [WL:0] wlo;
	logic signed [WH-1:0] whi;

	assign wlo = $signed({1'b0, w_s2[WL-1:0]});
	assign whi = w_s2[XW-1:WL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= PW'(h00) * PW'(qx);
			p01_s1  <= PW'(h01) * PW'(qy);
			p10_s1  <= PW'(h10) * PW'(qx);
			p11_s1  <= PW'(h11) * PW'(qy);
			p20_s1  <= PW'(h20) * PW'(qx);
			p21_s1  <= PW'(h21) * PW'(qy);
			tx_s1   <= tx;
			ty_s1   <= ty;
			echo_s1 <= {qx, qy, tx, ty};

			xn_s2   <= XW'(p00_s1) + XW'(p01_s1) + t02;
			yn_s2   <= XW'(p10_s1) + XW'(p11_s1) + t12;
			w_s2    <= XW'(p20_s1) + XW'(p21_s1) + t22;
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			echo_s2 <= echo_s1;

			deg_s3  <= (w_s2 == '0);
			xs_s3   <= EW'(xn_s2) <<< 10;
			ys_s3   <= EW'(yn_s2) <<< 10;
			txl_s3  <= (C+WL+1)'(tx_s2) * (C+WL+1)'(wlo);
			tyl_s3  <= (C+WL+1)'(ty_s2) * (C+WL+1)'(wlo);
			txh_s3  <= (C+WH)'(tx_s2) * (C+WH)'(whi);
			tyh_s3  <= (C+WH)'(ty_s2) * (C+WH)'(whi);
			tw_s3   <= (XW+THR_W+1)'(thr) * (XW+THR_W+1)'(w_s2);
			echo_s3 <= echo_s2;

			ex_s4   <= xs_s3 - ((EW'(txh_s3) <<< WL) + EW'(txl_s3));
			ey_s4   <= ys_s3 - ((EW'(tyh_s3) <<< WL) + EW'(tyl_s3));
			tw_s4   <= EW'(tw_s3);
			deg_s4  <= deg_s3;
			echo_s4 <= echo_s3;
		end
	end

	assign v_out    = v_s4;
	assign deg_out  = deg_s4;
	assign echo_out = echo_s4;
	assign ex_out   = ex_s4;
	assign ey_out   = ey_s4;
	assign tw_out   = tw_s4;
endmodule
`default_nettype wire

@@ design/hic_sq.sv @@
// Pipelined exact squarer, four stages: magnitude, three-limb partial
// products, two partial sums, final sum. Depends on hic_pkg.
`default_nettype none
module hic_sq import hic_pkg::*; #(
	parameter int unsigned N = 2 * COORD_W_DEF + COEF_W_DEF + 3
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic signed [N-1:0] a,
	output logic [2*N-1:0] sq
);
	localparam int unsigned L = (N + 2) / 3;
	localparam int unsigned SW = 6 * L;

	logic [N-1:0] mag_s1;
	logic [3*L-1:0] m;
	logic [L-1:0] a0, a1, a2;
	logic [2*L-1:0] p00_s2, p01_s2, p02_s2, p11_s2, p12_s2, p22_s2;
	logic [SW-1:0] sa_s3, sb_s3, sq_s4;

	assign m  = (3*L)'(mag_s1);
	assign a0 = m[L-1:0];
	assign a1 = m[2*L-1:L];
	assign a2 = m[3*L-1:2*L];

	always_ff @(posedge clk) begin
		if (en) begin
			// most negative input gives 2^(N-1), still fits unsigned N bits
			mag_s1 <= a[N-1] ? N'(-a) : N'(a);
			p00_s2 <= (2*L)'(a0) * (2*L)'(a0);
			p01_s2 <= (2*L)'(a0) * (2*L)'(a1);
			p02_s2 <= (2*L)'(a0) * (2*L)'(a2);
			p11_s2 <= (2*L)'(a1) * (2*L)'(a1);
			p12_s2 <= (2*L)'(a1) * (2*L)'(a2);
			p22_s2 <= (2*L)'(a2) * (2*L)'(a2);
			// cross terms appear twice, hence the extra shift
			sa_s3  <= SW'(p00_s2) + (SW'(p01_s2) << (L + 1)) + (SW'(p11_s2) << (2 * L));
			sb_s3  <= (SW'(p02_s2) << (2 * L + 1)) + (SW'(p12_s2) << (3 * L + 1))
				+ (SW'(p22_s2) << (4 * L));
			sq_s4  <= sa_s3 + sb_s3;
		end
	end

	assign sq = sq_s4[2*N-1:0];
endmodule
`default_nettype wire

@@ design/homography_inlier_check.sv @@
// Homography inlier check. An accepted pair passes 4 projection stages, 4 squarer
// stages, the error sum and the compare/output register on its way to the result.
// Throughput one pair per cycle; the whole pipe advances unless the output
// register holds a result the sink has not taken.
// arst_n clears valid bits and loads register defaults (h22 = 1.0, t = 3.0).
`default_nettype none
module homography_inlier_check import hic_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_W_DEF,
	parameter int unsigned COEF_WIDTH = COEF_W_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hic_cfg_if.sink       cfg,
	hic_pair_if.sink      pair_in,
	hic_result_if.source  result_out
);
	localparam int unsigned C = COORD_WIDTH;
	localparam int unsigned XW = COEF_WIDTH + C + 2;
	localparam int unsigned EW = C + XW + 1;
	localparam int unsigned QW = 2 * EW;

	coef_t coef;
	logic en;
	logic v_s4, deg_s4;
	logic [4*C-1:0] echo_s4;
	logic signed [EW-1:0] ex_s4, ey_s4, tw_s4;
	logic [QW-1:0] sqx, sqy, sqt;

	logic [3:0] v_dly_q, deg_dly_q;
	logic [4*C-1:0] echo_dly_q [4];
	logic v_s9, deg_s9;
	logic [4*C-1:0] echo_s9;
	logic [QW:0] esum_s9;
	logic [QW-1:0] tw2_s9;
	logic v_s10, inl_s10, deg_s10;
	logic [4*C-1:0] echo_s10;

	assign en = !v_s10 || result_out.ready;
	assign pair_in.ready = en;

	hic_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	hic_proj #(.C(C), .K(COEF_WIDTH), .XW(XW), .EW(EW)) u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pair_in.valid),
		.qx       (pair_in.query_x),
		.qy       (pair_in.query_y),
		.tx       (pair_in.train_x),
		.ty       (pair_in.train_y),
		.coef     (coef),
		.v_out    (v_s4),
		.deg_out  (deg_s4),
		.echo_out (echo_s4),
		.ex_out   (ex_s4),
		.ey_out   (ey_s4),
		.tw_out   (tw_s4)
	);

	hic_sq #(.N(EW)) u_sq_ex (.clk(clk), .en(en), .a(ex_s4), .sq(sqx));
	hic_sq #(.N(EW)) u_sq_ey (.clk(clk), .en(en), .a(ey_s4), .sq(sqy));
	hic_sq #(.N(EW)) u_sq_tw (.clk(clk), .en(en), .a(tw_s4), .sq(sqt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_dly_q <= '0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
		end else if (en) begin
			v_dly_q <= {v_dly_q[2:0], v_s4};
			v_s9    <= v_dly_q[3];
			v_s10   <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// side data follows the squarer latency
			deg_dly_q     <= {deg_dly_q[2:0], deg_s4};
			echo_dly_q[0] <= echo_s4;
			echo_dly_q[1] <= echo_dly_q[0];
			echo_dly_q[2] <= echo_dly_q[1];
			echo_dly_q[3] <= echo_dly_q[2];

			esum_s9 <= (QW+1)'(sqx) + (QW+1)'(sqy);
			tw2_s9  <= sqt;
			deg_s9  <= deg_dly_q[3];
			echo_s9 <= echo_dly_q[3];

			inl_s10  <= !deg_s9 && ((QW+1)'(tw2_s9) >= esum_s9);
			deg_s10  <= deg_s9;
			echo_s10 <= echo_s9;
		end
	end

	assign result_out.valid        = v_s10;
	assign result_out.is_inlier    = inl_s10;
	assign result_out.degenerate   = deg_s10;
	assign result_out.pair_query_x = echo_s10[4*C-1:3*C];
	assign result_out.pair_query_y = echo_s10[3*C-1:2*C];
	assign result_out.pair_train_x = echo_s10[2*C-1:C];
	assign result_out.pair_train_y = echo_s10[C-1:0];

`ifndef SYNTHESIS
	a_deg_not_inlier: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> !(result_out.is_inlier && result_out.degenerate))
		else $error("degenerate pair flagged as inlier");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.ready) |-> !pair_in.ready)
		else $error("input accepted while output stalled");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.ready) |=> $stable(v_s9) && $stable(v_dly_q))
		else $error("pipeline moved during stall");
`endif
endmodule
`default_nettype wire
